[sv/cmrs_pkg.sv]
// shared constants, codes and types of the cost matrix min row sum block
package cmrs_pkg;

	localparam int MAX_AGENTS  = 16;
	localparam int COST_BITS   = 32;
	localparam int AGENT_RESET = 16;

	// fixed port widths
	localparam int COST_W   = 32;
	localparam int IDX_W    = 4;
	localparam int AGENT_W  = 5;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	// derived storage widths
	localparam int STORE_BITS = (COST_BITS < 32) ? COST_BITS : 32;
	localparam int IDX_BITS   = $clog2(MAX_AGENTS);
	localparam int CNT_BITS   = $clog2(MAX_AGENTS + 1);
	localparam int CELLS      = MAX_AGENTS * MAX_AGENTS;
	localparam int ADDR_BITS  = 2 * IDX_BITS;
	localparam int ACC_BITS   = STORE_BITS + IDX_BITS;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SEARCH,
		S_DRAIN,
		S_RESULT
	} fsm_state_t;

	typedef struct packed {
		logic                  wr_en;
		logic [ADDR_BITS-1:0]  wr_addr;
		logic [STORE_BITS-1:0] wr_data;
		logic                  rd_en;
		logic [ADDR_BITS-1:0]  rd_addr;
		logic                  clear;
	} cmrs_req_t;

endpackage

[sv/cmrs_store.sv]
// cost memory with per-entry valid bits, one write and one registered read per cycle
module cmrs_store import cmrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmrs_req_t             req,
	output logic [STORE_BITS-1:0] rd_data
);

	logic [STORE_BITS-1:0] mem_q [CELLS];
	logic [CELLS-1:0]      valid_q;
	logic [STORE_BITS-1:0] rd_raw_s1;
	logic                  rd_valid_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_s1 <= mem_q[req.rd_addr];
		end
	end

	// clear wins over a write in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_s1 <= valid_q[req.rd_addr];
			end
		end
	end

	// entries never written since the last clear read as zero
	assign rd_data = rd_valid_s1 ? rd_raw_s1 : '0;

`ifndef ASSERT_OFF
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		req.clear |=> valid_q == '0)
		else $error("valid bits not cleared");

	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en && !req.clear |=> valid_q[$past(req.wr_addr)])
		else $error("write did not mark entry valid");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en && !valid_q[req.rd_addr] |=> rd_data == '0)
		else $error("unwritten entry read nonzero");
`endif

endmodule

[sv/cost_matrix_min_row_sum.sv]
// top level: cost matrix with read, write and minimum row sum search
//
//  channel  signals                                     direction  accepted when
//  config   cfg_wr_en, cfg_wr_data                      in         cfg_wr_en high
//  input    in_valid, in_stall, cmd, from_index,        in         in_valid & !in_stall
//           to_index, cost_in
//  output   out_valid, out_stall, cost_out,             out        out_valid & !out_stall
//           is_reachable, best_row, status
//
// write, error and unused-command beats finish in the accept cycle; a read waits on the registered memory read
// a search runs through the accept cycle, one cell read per cycle, then the row-total and
// compare stages
// the single memory read port sets the search length; one item is in flight at a time
// a result waiting on out_stall parks in a holding register; no new beat is taken meanwhile
// reset and any config write clear all costs at once through per-entry valid bits
module cost_matrix_min_row_sum import cmrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [AGENT_W-1:0]       cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [IDX_W-1:0]         from_index,
	input  logic [IDX_W-1:0]         to_index,
	input  logic signed [COST_W-1:0] cost_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [COST_W-1:0] cost_out,
	output logic                     is_reachable,
	output logic [IDX_W-1:0]         best_row,
	output logic [STATUS_W-1:0]      status
);

	// control state
	fsm_state_t            state_q, state_d;
	logic [CNT_BITS-1:0]   side_q;
	cmrs_req_t             store_req;
	logic [STORE_BITS-1:0] rd_data;

	// search read sequencer
	logic [IDX_BITS-1:0]   row_q, col_q;
	logic [IDX_BITS-1:0]   last_idx;
	logic                  col_last, row_last;
	logic                  search_start, search_step;

	// tags that travel with the read data
	logic                  vld_s1, first_s1, last_s1, final_s1;
	logic [IDX_BITS-1:0]   row_s1;

	// row accumulation and row totals
	logic signed [ACC_BITS-1:0] acc_q, sum_c;
	logic signed [ACC_BITS-1:0] total_s2, best_sum_q;
	logic                       tot_vld_s2, tot_final_s2;
	logic [IDX_BITS-1:0]        tot_row_s2, best_row_q, best_row_c;
	logic                       take_c;

	// finished result, out register, holding register
	logic                     out_free, idx_ok;
	logic                     fin_valid;
	logic signed [COST_W-1:0] fin_cost;
	logic                     fin_reach;
	logic [IDX_W-1:0]         fin_best;
	status_t                  fin_status;

	logic                     out_valid_q;
	logic signed [COST_W-1:0] out_cost_q;
	logic                     out_reach_q;
	logic [IDX_W-1:0]         out_best_q;
	status_t                  out_status_q;

	logic signed [COST_W-1:0] res_cost_q;
	logic                     res_reach_q;
	logic [IDX_W-1:0]         res_best_q;
	status_t                  res_status_q;

	cmrs_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_data (rd_data)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign idx_ok   = (int'(from_index) < int'(side_q)) && (int'(to_index) < int'(side_q));

	// side is at least one whenever a search runs
	assign last_idx = IDX_BITS'(side_q - CNT_BITS'(1));
	assign col_last = (col_q == last_idx);
	assign row_last = (row_q == last_idx);

	// first row always seeds the best; strict less-than keeps the lowest row on ties
	assign take_c     = (tot_row_s2 == '0) || (total_s2 < best_sum_q);
	assign best_row_c = take_c ? tot_row_s2 : best_row_q;

	// config: saturate the agent count to the matrix size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= CNT_BITS'((AGENT_RESET > MAX_AGENTS) ? MAX_AGENTS : AGENT_RESET);
		end else if (cfg_wr_en) begin
			if (int'(cfg_wr_data) > MAX_AGENTS) begin
				side_q <= CNT_BITS'(MAX_AGENTS);
			end else begin
				side_q <= CNT_BITS'(cfg_wr_data);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		fin_valid    = 1'b0;
		fin_cost     = '0;
		fin_reach    = 1'b0;
		fin_best     = '0;
		fin_status   = ST_OK;
		search_start = 1'b0;
		search_step  = 1'b0;

		store_req         = '0;
		store_req.wr_addr = {IDX_BITS'(from_index), IDX_BITS'(to_index)};
		store_req.wr_data = cost_in[STORE_BITS-1:0];
		store_req.rd_addr = {row_q, col_q};
		store_req.clear   = cfg_wr_en;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd)
						CMD_WRITE: begin
							fin_valid = 1'b1;
							if (idx_ok) begin
								store_req.wr_en = 1'b1;
							end else begin
								fin_status = ST_RANGE;
							end
						end
						CMD_READ: begin
							if (idx_ok) begin
								store_req.rd_en   = 1'b1;
								store_req.rd_addr = {IDX_BITS'(from_index),
									IDX_BITS'(to_index)};
								state_d = S_READ;
							end else begin
								fin_valid  = 1'b1;
								fin_status = ST_RANGE;
							end
						end
						CMD_SEARCH: begin
							if (side_q == '0) begin
								fin_valid  = 1'b1;
								fin_status = ST_EMPTY;
							end else begin
								search_start = 1'b1;
								state_d      = S_SEARCH;
							end
						end
						default: begin
							// unused command: all-zero ok result
							fin_valid = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				fin_valid = 1'b1;
				fin_cost  = COST_W'($signed(rd_data));
				fin_reach = !rd_data[STORE_BITS-1] && (rd_data != '0);
			end
			S_SEARCH: begin
				store_req.rd_en = 1'b1;
				search_step     = 1'b1;
				if (col_last && row_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (tot_vld_s2 && tot_final_s2) begin
					fin_valid = 1'b1;
					fin_best  = IDX_W'(best_row_c);
				end
			end
			S_RESULT: begin
				fin_valid  = 1'b1;
				fin_cost   = res_cost_q;
				fin_reach  = res_reach_q;
				fin_best   = res_best_q;
				fin_status = res_status_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// a finished beat goes out now, or waits in the holding register
		if (fin_valid) begin
			state_d = out_free ? S_IDLE : S_RESULT;
		end
	end

	// cell sequencer: column fastest, row slowest
	always_ff @(posedge clk) begin
		if (search_start) begin
			row_q <= '0;
			col_q <= '0;
		end else if (search_step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + IDX_BITS'(1);
			end else begin
				col_q <= col_q + IDX_BITS'(1);
			end
		end
		row_s1   <= row_q;
		first_s1 <= (col_q == '0);
		last_s1  <= col_last;
		final_s1 <= col_last && row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			tot_vld_s2 <= 1'b0;
		end else begin
			vld_s1     <= search_step;
			tot_vld_s2 <= vld_s1 && last_s1;
		end
	end

	assign sum_c = (first_s1 ? ACC_BITS'(0) : acc_q) + ACC_BITS'($signed(rd_data));

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (last_s1) begin
				total_s2     <= sum_c;
				tot_row_s2   <= row_s1;
				tot_final_s2 <= final_s1;
			end else begin
				acc_q <= sum_c;
			end
		end
		if (tot_vld_s2) begin
			if (take_c) begin
				best_sum_q <= total_s2;
			end
			best_row_q <= best_row_c;
		end
	end

	// output register and holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && out_free) begin
			out_cost_q   <= fin_cost;
			out_reach_q  <= fin_reach;
			out_best_q   <= fin_best;
			out_status_q <= fin_status;
		end
		if (fin_valid && !out_free) begin
			res_cost_q   <= fin_cost;
			res_reach_q  <= fin_reach;
			res_best_q   <= fin_best;
			res_status_q <= fin_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign cost_out     = out_cost_q;
	assign is_reachable = out_reach_q;
	assign best_row     = out_best_q;
	assign status       = out_status_q;

`ifndef ASSERT_OFF
	a_tags_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 || tot_vld_s2 |-> state_q == S_SEARCH || state_q == S_DRAIN)
		else $error("search pipeline active outside a search");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> cost_out == '0 && !is_reachable && best_row == '0)
		else $error("error beat carries payload");

	a_reach_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_reachable |-> !cost_out[COST_W-1] && cost_out != '0)
		else $error("reachable flag on a non-positive cost");
`endif

endmodule

[dv/cost_matrix_min_row_sum_test.sv]
// self-checking testbench for the cost matrix min row sum block
module cost_matrix_min_row_sum_test;
	import cmrs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// the one command code the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [COST_W-1:0] COST_MAX = 32'h7FFF_FFFF;
	localparam logic signed [COST_W-1:0] COST_MIN = 32'h8000_0000;

	localparam int PHASES         = 10;
	localparam int BEATS_PER_SIDE = 190;  // random beats in a phase with agents in use
	localparam int BEATS_EMPTY    = 40;   // random beats in the zero-agent phase
	localparam int HOLD_CYCLES    = 200;  // long receiver hold-off
	localparam int SETTLE_CYCLES  = 300;  // a full-size search plus margin
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic [IDX_W-1:0]         from_idx;
		logic [IDX_W-1:0]         to_idx;
		logic signed [COST_W-1:0] cost;
	} matrix_op_t;

	typedef struct {
		logic signed [COST_W-1:0] cost;
		logic                     reach;
		logic [IDX_W-1:0]         row;
		status_t                  status;
	} matrix_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [AGENT_W-1:0]       cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         cmd = CMD_WRITE;
	logic [IDX_W-1:0]         from_index = '0;
	logic [IDX_W-1:0]         to_index = '0;
	logic signed [COST_W-1:0] cost_in = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [COST_W-1:0] cost_out;
	logic                     is_reachable;
	logic [IDX_W-1:0]         best_row;
	logic [STATUS_W-1:0]      status;

	cost_matrix_min_row_sum i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.from_index   (from_index),
		.to_index     (to_index),
		.cost_in      (cost_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cost_out     (cost_out),
		.is_reachable (is_reachable),
		.best_row     (best_row),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the block state
	logic signed [COST_W-1:0] cost_grid [MAX_AGENTS][MAX_AGENTS];
	logic [AGENT_W-1:0]       agent_reg;

	matrix_op_t     pending_ops[$];       // beats waiting for the driver
	matrix_result_t expected_results[$];  // predicted results, oldest first

	// stimulus knobs, set by the sequence below
	bit idling_on = 1'b1;
	bit hold_request = 1'b0;

	// bookkeeping, updated at the rising edge
	bit in_taken = 1'b0;
	int beats_loaded = 0;
	int beats_accepted = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int agent_writes = 0;
	int write_beats = 0;
	int read_beats = 0;
	int search_beats = 0;
	int other_beats = 0;
	int error_results = 0;

	// expected result of one beat; updates the shadow matrix on a write
	function automatic matrix_result_t compute_matrix_result(matrix_op_t op);
		matrix_result_t res;
		int             n;
		longint         row_total;
		longint         lowest_total;
		res = '{cost: '0, reach: 1'b0, row: '0, status: ST_OK};
		// an oversized agent count saturates to the full matrix
		n = (agent_reg > MAX_AGENTS) ? MAX_AGENTS : int'(agent_reg);
		case (op.cmd)
			CMD_WRITE, CMD_READ: begin
				if (op.from_idx >= n || op.to_idx >= n) begin
					res.status = ST_RANGE;
				end else if (op.cmd == CMD_WRITE) begin
					cost_grid[op.from_idx][op.to_idx] = op.cost;
				end else begin
					res.cost  = cost_grid[op.from_idx][op.to_idx];
					res.reach = (cost_grid[op.from_idx][op.to_idx] > 0);
				end
			end
			CMD_SEARCH: begin
				if (n == 0) begin
					res.status = ST_EMPTY;
				end else begin
					lowest_total = 0;
					for (int r = 0; r < n; r++) begin
						row_total = 0;
						for (int c = 0; c < n; c++)
							row_total += cost_grid[r][c];
						// strict compare keeps the lowest row on a tie
						if (r == 0 || row_total < lowest_total) begin
							lowest_total = row_total;
							res.row      = IDX_W'(r);
						end
					end
				end
			end
			default: ;  // unused command: all fields zero, status ok
		endcase
		return res;
	endfunction

	function automatic logic signed [COST_W-1:0] pick_cost();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return COST_W'($urandom_range(0, 6)) - COST_W'(3);  // ties likely
			7:          return COST_MAX;
			8:          return COST_MIN;
			default:    return {16'($urandom_range(0, 65535)), 16'h0};  // whole numbers
		endcase
	endfunction

	// mostly well-formed beats inside the matrix, the rest noise and bad indexes
	function automatic matrix_op_t random_op(int n);
		matrix_op_t op;
		int         roll;
		roll        = $urandom_range(0, 99);
		op.cmd      = CMD_W'($urandom_range(0, 3));
		op.from_idx = IDX_W'($urandom_range(0, MAX_AGENTS - 1));
		op.to_idx   = IDX_W'($urandom_range(0, MAX_AGENTS - 1));
		op.cost     = pick_cost();
		if (n == 0 || roll < 8)
			return op;
		if (roll < 13) begin
			if (n < MAX_AGENTS) begin
				op.cmd = roll[0] ? CMD_READ : CMD_WRITE;
				if (roll < 11)
					op.from_idx = IDX_W'($urandom_range(n, MAX_AGENTS - 1));
				else
					op.to_idx = IDX_W'($urandom_range(n, MAX_AGENTS - 1));
			end
			return op;
		end
		op.from_idx = IDX_W'($urandom_range(0, n - 1));
		op.to_idx   = IDX_W'($urandom_range(0, n - 1));
		if (roll < 60)
			op.cmd = CMD_WRITE;
		else if (roll < 88)
			op.cmd = CMD_READ;
		else if (roll < 96)
			op.cmd = CMD_SEARCH;
		else
			op.cmd = CMD_UNUSED;
		return op;
	endfunction

	task automatic load_op(logic [CMD_W-1:0] c, int f, int t, logic signed [COST_W-1:0] v);
		pending_ops.push_back('{cmd: c, from_idx: IDX_W'(f), to_idx: IDX_W'(t), cost: v});
		beats_loaded++;
	endtask

	// block is idle once every loaded beat went in and every result came out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (beats_accepted != beats_loaded || expected_results.size() != 0);
	endtask

	task automatic write_agent_count(logic [AGENT_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic check_field(string field, logic [COST_W-1:0] want, logic [COST_W-1:0] got);
		if (want !== got) begin
			$display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// input driver: a new beat only after the last one was taken
	always @(negedge clk) begin
		matrix_op_t op;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_ops.size() != 0 && !(idling_on && $urandom_range(0, 99) < 28)) begin
				op = pending_ops.pop_front();
				cmd        <= op.cmd;
				from_index <= op.from_idx;
				to_index   <= op.to_idx;
				cost_in    <= op.cost;
				in_valid   <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls, plus one long hold-off on request
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idling_on && ($urandom_range(0, 99) < 28);
		end
	end

	// monitor: tracks config, predicts every input beat, checks every result beat
	always @(posedge clk) begin
		matrix_result_t want;
		if (!arst_n) begin
			agent_reg = AGENT_W'(AGENT_RESET);
			foreach (cost_grid[r, c])
				cost_grid[r][c] = '0;
			in_taken = 1'b0;
		end else begin
			quiet_cycles++;
			in_taken = in_valid && !in_stall;
			if (cfg_wr_en) begin
				// a new agent count rebuilds the matrix
				agent_reg = cfg_wr_data;
				foreach (cost_grid[r, c])
					cost_grid[r][c] = '0;
				agent_writes++;
				quiet_cycles = 0;
			end
			if (in_taken) begin
				expected_results.push_back(compute_matrix_result(
					'{cmd: cmd, from_idx: from_index, to_idx: to_index, cost: cost_in}));
				beats_accepted++;
				quiet_cycles = 0;
				case (cmd)
					CMD_WRITE:  write_beats++;
					CMD_READ:   read_beats++;
					CMD_SEARCH: search_beats++;
					default:    other_beats++;
				endcase
			end
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (expected_results.size() == 0) begin
					$display("%0t result beat with nothing expected: cost %h reach %b row %0d status %0d",
						$time, cost_out, is_reachable, best_row, status);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("cost_out", want.cost, cost_out);
					check_field("is_reachable", COST_W'(want.reach), COST_W'(is_reachable));
					check_field("best_row", COST_W'(want.row), COST_W'(best_row));
					check_field("status", COST_W'(want.status), COST_W'(status));
					if (want.status != ST_OK)
						error_results++;
					results_checked++;
				end
			end
			// watchdog: nothing moved on any channel for too long
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// sequence: reset, then phases at different agent counts
	initial begin
		logic [AGENT_W-1:0] agent_plan [PHASES];
		int                 side;
		int                 count;
		// phase 0 runs at the reset count; zero, one, the saturating values and a
		// random size follow
		agent_plan = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd2, 5'd16, 5'd3, 5'd17, 5'd8, 5'd0};
		agent_plan[PHASES-1] = AGENT_W'($urandom_range(4, 15));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
				write_agent_count(agent_plan[p]);
			end
			side = (agent_plan[p] > MAX_AGENTS) ? MAX_AGENTS : int'(agent_plan[p]);
			// one phase with no idling on either side
			idling_on = (p != 5);

			case (p)
				0: begin
					// fresh matrix: zeros read as unreachable, search falls on row 0
					load_op(CMD_READ, 0, 0, '0);
					load_op(CMD_SEARCH, 0, 0, '0);
					load_op(CMD_WRITE, 0, 0, COST_MAX);
					load_op(CMD_READ, 0, 0, '0);
					load_op(CMD_WRITE, 15, 15, COST_MIN);
					load_op(CMD_READ, 15, 15, '0);
					// smallest positive cost is reachable, minus one is not
					load_op(CMD_WRITE, 3, 7, 32'sd1);
					load_op(CMD_READ, 3, 7, '0);
					load_op(CMD_WRITE, 3, 8, -32'sd1);
					load_op(CMD_READ, 3, 8, '0);
					load_op(CMD_SEARCH, 9, 4, '0);
					load_op(CMD_UNUSED, 15, 15, COST_MIN);
					// several rows tie at zero: lowest one wins
					load_op(CMD_WRITE, 15, 15, '0);
					load_op(CMD_SEARCH, 15, 15, '0);
				end
				1: begin
					// no agents: writes and reads out of range, search on an empty grid
					load_op(CMD_WRITE, 0, 0, 32'sd5);
					load_op(CMD_READ, 0, 0, '0);
					load_op(CMD_SEARCH, 0, 0, '0);
					load_op(CMD_UNUSED, 0, 0, '0);
				end
				2: begin
					// single agent: only cell 0,0 is valid
					load_op(CMD_WRITE, 0, 1, 32'sd7);
					load_op(CMD_READ, 1, 0, '0);
					load_op(CMD_WRITE, 0, 0, -32'sd5);
					load_op(CMD_READ, 0, 0, '0);
					load_op(CMD_SEARCH, 0, 0, '0);
				end
				3: begin
					// saturated count: full matrix, cleared by the config write
					load_op(CMD_READ, 15, 15, '0);
					load_op(CMD_WRITE, 15, 15, 32'sd1);
					load_op(CMD_READ, 15, 15, '0);
				end
				6: hold_request = 1'b1;  // receiver holds off while beats keep coming
				default: ;
			endcase

			count = (side == 0) ? BEATS_EMPTY : BEATS_PER_SIDE;
			for (int k = 0; k < count; k++)
				pending_ops.push_back(random_op(side));
			beats_loaded += count;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d writes, %0d reads, %0d searches, %0d unused-command beats",
			write_beats, read_beats, search_beats, other_beats);
		$display("over %0d agent count settings; %0d results checked, %0d with error status",
			agent_writes, results_checked, error_results);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
